// ===== src/qformat_fixed_point_alu_assert.svh =====
// Assertion macros for the checker file.
`ifndef QFORMAT_FIXED_POINT_ALU_ASSERT_SVH
`define QFORMAT_FIXED_POINT_ALU_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define QFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define QFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/qfalu_pkg.sv =====
package qfalu_pkg;

  // Default word width of the arithmetic
  localparam int DATA_WIDTH_DEF = 32;

  // Field widths and tdata layout of the input channel
  localparam int Q_W        = 5;
  localparam int OPND_W     = 32;
  localparam int OP_W       = 2;
  localparam int A_LSB      = 0;
  localparam int QA_LSB     = A_LSB + OPND_W;
  localparam int B_LSB      = QA_LSB + Q_W;
  localparam int QB_LSB     = B_LSB + OPND_W;
  localparam int QR_LSB     = QB_LSB + Q_W;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MSHIFT,
    ST_DIV,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic mshift;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    op_t  op;
    logic div_zero;
    logic div_last;
  } sts_t;

endpackage

// ===== src/qfalu_ctrl.sv =====
module qfalu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  qfalu_pkg::sts_t   sts,
  output qfalu_pkg::cmd_t   cmd
);

  qfalu_pkg::state_t state_r, state_nxt;
  logic              out_vld_r, out_vld_nxt;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= qfalu_pkg::ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      qfalu_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = qfalu_pkg::ST_PREP;
        end
      end
      qfalu_pkg::ST_PREP: begin
        cmd.prep = 1'b1;
        case (sts.op)
          qfalu_pkg::OP_MUL: state_nxt = qfalu_pkg::ST_MSHIFT;
          qfalu_pkg::OP_DIV: begin
            state_nxt = sts.div_zero ? qfalu_pkg::ST_DONE : qfalu_pkg::ST_DIV;
          end
          default: state_nxt = qfalu_pkg::ST_DONE;
        endcase
      end
      qfalu_pkg::ST_MSHIFT: begin
        cmd.mshift = 1'b1;
        state_nxt  = qfalu_pkg::ST_DONE;
      end
      qfalu_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = qfalu_pkg::ST_DONE;
        end
      end
      qfalu_pkg::ST_DONE: begin
        // Hand the result over once the output register is free
        if (!out_vld_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = qfalu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qfalu_pkg::ST_IDLE;
    endcase
  end

  // Hold the output until its transfer completes
  always_comb begin
    if (cmd.out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  assign out_tvalid = out_vld_r;

endmodule

// ===== src/qfalu_dp.sv =====
module qfalu_dp #(
  parameter int DATA_WIDTH = qfalu_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic [qfalu_pkg::OP_W-1:0]       in_op,
  input  logic [qfalu_pkg::IN_DATA_W-1:0]  in_data,
  input  qfalu_pkg::cmd_t                  cmd,
  output qfalu_pkg::sts_t                  sts,
  output logic [qfalu_pkg::OUT_DATA_W-1:0] out_result,
  output logic                             out_dz
);

  localparam int W  = DATA_WIDTH;
  localparam int QW = qfalu_pkg::Q_W;
  localparam int CW = $clog2(DATA_WIDTH + 63);

  // Shift one operand to the result format: left drops high bits, right is arithmetic
  function automatic logic [W-1:0] align_q(input logic [W-1:0] w,
                                            input logic [QW-1:0] qf,
                                            input logic [QW-1:0] qt);
    logic [QW-1:0] d;
    d = (qt > qf) ? (qt - qf) : (qf - qt);
    if (qt > qf) begin
      return w << d;
    end
    return W'($signed(w) >>> d);
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    return x[W-1] ? (W'(0) - x) : x;
  endfunction

  qfalu_pkg::op_t  op_r;
  logic [W-1:0]    a_r, b_r, ma_r, mb_r;
  logic [QW-1:0]   qa_r, qb_r, qr_r;
  logic            neg_r, dz_r;
  logic [W-1:0]    res_r, dvd_r, rem_r;
  logic [2*W-1:0]  prod_r;
  logic [CW-1:0]   cnt_r;
  logic [W-1:0]    out_res_r;
  logic            out_dz_r;

  logic [W-1:0]    in_a, in_b;
  logic [W-1:0]    ala, alb;
  logic            na, nb;
  logic [7:0]      rdiv, rneg;
  logic [QW:0]     qp, qr_ext;
  logic [QW:0]     sr_amt;
  logic [QW-1:0]   sl_amt;
  logic [2*W-1:0]  prod_shl, prod_shr;
  logic [W:0]      rem_sh, rem_diff;
  logic            ge;

  assign in_a = in_data[qfalu_pkg::A_LSB +: W];
  assign in_b = in_data[qfalu_pkg::B_LSB +: W];
  assign na   = a_r[W-1];
  assign nb   = b_r[W-1];

  // Add/subtract alignment
  assign ala = align_q(a_r, qa_r, qr_r);
  assign alb = align_q(b_r, qb_r, qr_r);

  // Extra quotient bits for divide: q_b - q_a + q_result
  assign rdiv = {3'b000, qb_r} - {3'b000, qa_r} + {3'b000, qr_r};
  assign rneg = 8'd0 - rdiv;

  // Product rescale amounts
  assign qp       = {1'b0, qa_r} + {1'b0, qb_r};
  assign qr_ext   = {1'b0, qr_r};
  assign sl_amt   = QW'(qr_ext - qp);
  assign sr_amt   = qp - qr_ext;
  assign prod_shl = prod_r << sl_amt;
  assign prod_shr = prod_r >> sr_amt;

  // One restoring divide step
  assign rem_sh   = {rem_r, dvd_r[W-1]};
  assign rem_diff = rem_sh - {1'b0, mb_r};
  assign ge       = (rem_sh >= {1'b0, mb_r});

  always_ff @(posedge clk) begin
    // Capture the item and its operand magnitudes
    if (cmd.load) begin
      op_r <= qfalu_pkg::op_t'(in_op);
      a_r  <= in_a;
      b_r  <= in_b;
      ma_r <= mag(in_a);
      mb_r <= mag(in_b);
      qa_r <= in_data[qfalu_pkg::QA_LSB +: QW];
      qb_r <= in_data[qfalu_pkg::QB_LSB +: QW];
      qr_r <= in_data[qfalu_pkg::QR_LSB +: QW];
    end

    // First operation cycle
    if (cmd.prep) begin
      neg_r <= 1'b0;
      dz_r  <= 1'b0;
      case (op_r)
        qfalu_pkg::OP_ADD: res_r <= ala + alb;
        qfalu_pkg::OP_SUB: res_r <= ala - alb;
        qfalu_pkg::OP_MUL: begin
          prod_r <= (2*W)'(ma_r) * (2*W)'(mb_r);
          neg_r  <= na ^ nb;
        end
        qfalu_pkg::OP_DIV: begin
          res_r <= '0;
          rem_r <= '0;
          if (mb_r == '0) begin
            dz_r <= 1'b1;
          end else begin
            neg_r <= na ^ nb;
            if (rdiv[7]) begin
              dvd_r <= ma_r >> rneg[QW-1:0];
              cnt_r <= CW'(W);
            end else begin
              dvd_r <= ma_r;
              cnt_r <= CW'(W) + CW'(rdiv[6:0]);
            end
          end
        end
        default: res_r <= '0;
      endcase
    end

    // Rescale the product to the result format
    if (cmd.mshift) begin
      res_r <= (qr_ext >= qp) ? prod_shl[W-1:0] : prod_shr[W-1:0];
    end

    // Advance the divider by one quotient bit
    if (cmd.div_step) begin
      rem_r <= ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
      res_r <= {res_r[W-2:0], ge};
      dvd_r <= dvd_r << 1;
      cnt_r <= cnt_r - 1'b1;
    end

    // Restore the sign into the output register
    if (cmd.out_load) begin
      out_res_r <= neg_r ? (W'(0) - res_r) : res_r;
      out_dz_r  <= dz_r;
    end
  end

  assign sts.op       = op_r;
  assign sts.div_zero = (mb_r == '0);
  assign sts.div_last = (cnt_r == CW'(1));

  assign out_result = qfalu_pkg::OUT_DATA_W'(out_res_r);
  assign out_dz     = out_dz_r;

endmodule

// ===== src/qformat_fixed_point_alu.sv =====
// Q-format fixed-point ALU: add, subtract, multiply and divide of two
// DATA_WIDTH-bit two's complement words, each with its own count of
// fractional bits, giving one word in the requested format that wraps on
// overflow. One item is worked at a time. After an item is taken, PREP and
// DONE follow for add, subtract and a zero divisor, PREP, MSHIFT and DONE for
// multiply, and PREP, DIV and DONE for divide; DONE loads the output register
// once it is free, and then the next item is taken. In DIV the restoring
// divider yields one quotient bit per cycle, DATA_WIDTH + max(0, r) bits in
// all (up to DATA_WIDTH + 62), where r = q_b - q_a + q_result. A finished
// result waits in the output register while the next item is taken and worked.
module qformat_fixed_point_alu #(
  parameter int DATA_WIDTH = qfalu_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // operand_a[31:0], q_a[36:32], operand_b[68:37], q_b[73:69], q_result[78:74], pad
  input  logic [qfalu_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [qfalu_pkg::OP_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // result[31:0]
  output logic [qfalu_pkg::OUT_DATA_W-1:0] out_tdata,
  // divide_by_zero[0]
  output logic                             out_tuser
);

  qfalu_pkg::cmd_t cmd;
  qfalu_pkg::sts_t sts;

  qfalu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  qfalu_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .in_op      (in_tuser),
    .in_data    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_result (out_tdata),
    .out_dz     (out_tuser)
  );

endmodule

// ===== src/qfalu_checker.sv =====
`include "qformat_fixed_point_alu_assert.svh"

module qfalu_checker #(
  parameter int DATA_WIDTH = qfalu_pkg::DATA_WIDTH_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [qfalu_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                             out_tuser
);

  // A stalled result holds
  `QFA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // A zero divisor always gives a zero result word
  `QFA_ASSERT_NOW(a_dz_zero, out_tvalid && out_tuser, out_tdata == '0, "divide by zero with nonzero result")

  // One item at a time: no transfer right after a transfer
  `QFA_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "input taken while busy")

  // No result can appear the cycle after a transfer
  `QFA_ASSERT_NEXT(a_no_early, in_tvalid && in_tready && !out_tvalid, !out_tvalid, "result appeared too early")

endmodule

bind qformat_fixed_point_alu qfalu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qfalu_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 1800;
  localparam int STALL_PCT    = 8;
  localparam int DRAIN_CYCLES = 120;
  localparam int HANG_LIMIT   = 2000;
  localparam int QUIET_FIRST  = 700;
  localparam int QUIET_LAST   = 1000;
  localparam int HOLD_AT      = 400;

  // One ALU request as it travels on the input channel
  typedef struct {
    qfalu_pkg::op_t op;
    logic [31:0]    a;
    logic [4:0]     qa;
    logic [31:0]    b;
    logic [4:0]     qb;
    logic [4:0]     qr;
  } alu_req_t;

  // One ALU answer as it travels on the output channel
  typedef struct {
    logic [31:0] value;
    logic        dz;
  } alu_answer_t;

  // Directed stimulus row; fixed_answer marks rows whose answer is typed in
  typedef struct {
    alu_req_t    req;
    bit          fixed_answer;
    alu_answer_t answer;
  } stim_row_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [qfalu_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [qfalu_pkg::OP_W-1:0]       in_tuser   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [qfalu_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                             out_tuser;

  alu_answer_t pending_answers[$];
  stim_row_t   directed_rows[$];
  int          mismatch_count = 0;
  int          idle_cycles    = 0;
  bit          quiet          = 1'b0;

  qformat_fixed_point_alu dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  // Bring a word from one count of fractional bits to another, wrapping to 32 bits
  function automatic logic [31:0] align_to_q(logic [31:0] word, int q_from, int q_to);
    logic signed [63:0] wide;
    wide = {{32{word[31]}}, word};
    if (q_to > q_from)
      wide = wide << (q_to - q_from);
    else if (q_to < q_from)
      wide = wide >>> (q_from - q_to);
    return wide[31:0];
  endfunction

  // Work out the answer the ALU must give for one request
  function automatic alu_answer_t compute_answer(alu_req_t req);
    alu_answer_t ans;
    logic [63:0] mag_a, mag_b, prod, quo, rem;
    logic        neg_a, neg_b;
    int          qp, shift_r, i;
    ans.value = '0;
    ans.dz    = 1'b0;
    case (req.op)
      qfalu_pkg::OP_ADD: begin
        ans.value = align_to_q(req.a, req.qa, req.qr) + align_to_q(req.b, req.qb, req.qr);
      end
      qfalu_pkg::OP_SUB: begin
        ans.value = align_to_q(req.a, req.qa, req.qr) - align_to_q(req.b, req.qb, req.qr);
      end
      default: begin
        neg_a = req.a[31];
        neg_b = req.b[31];
        mag_a = neg_a ? 64'd0 - {{32{1'b1}}, req.a} : {32'd0, req.a};
        mag_b = neg_b ? 64'd0 - {{32{1'b1}}, req.b} : {32'd0, req.b};
        if (req.op == qfalu_pkg::OP_MUL) begin
          prod = mag_a * mag_b;
          qp   = int'(req.qa) + int'(req.qb);
          if (int'(req.qr) >= qp)
            prod = prod << (int'(req.qr) - qp);
          else
            prod = prod >> (qp - int'(req.qr));
          ans.value = prod[31:0];
        end else if (mag_b == 64'd0) begin
          // zero divisor: flag it, no sign fix
          ans.dz = 1'b1;
          neg_a  = neg_b;
        end else begin
          // restoring division, one quotient bit per step past the integer part
          shift_r = int'(req.qb) - int'(req.qa) + int'(req.qr);
          quo     = mag_a / mag_b;
          rem     = mag_a % mag_b;
          if (shift_r < 0) begin
            quo = quo >> (-shift_r);
          end else begin
            for (i = 0; i < shift_r; i++) begin
              rem = rem << 1;
              quo = quo << 1;
              if (rem >= mag_b) begin
                rem    = rem - mag_b;
                quo[0] = 1'b1;
              end
            end
          end
          ans.value = quo[31:0];
        end
        if (neg_a != neg_b)
          ans.value = 32'd0 - ans.value;
      end
    endcase
    return ans;
  endfunction

  task automatic add_row(qfalu_pkg::op_t op, logic [31:0] a, logic [4:0] qa,
                         logic [31:0] b, logic [4:0] qb, logic [4:0] qr,
                         bit fixed_answer, logic [31:0] value, logic dz);
    stim_row_t row;
    row.req          = '{op, a, qa, b, qb, qr};
    row.fixed_answer = fixed_answer;
    row.answer       = '{value, dz};
    directed_rows.push_back(row);
  endtask

  // Drive one request, hold it until the transfer, then queue its answer
  task automatic send_req(alu_req_t req, bit fixed_answer, alu_answer_t fixed);
    logic [qfalu_pkg::IN_DATA_W-1:0] word;
    word = '0;
    word[qfalu_pkg::A_LSB  +: qfalu_pkg::OPND_W] = req.a;
    word[qfalu_pkg::QA_LSB +: qfalu_pkg::Q_W]    = req.qa;
    word[qfalu_pkg::B_LSB  +: qfalu_pkg::OPND_W] = req.b;
    word[qfalu_pkg::QB_LSB +: qfalu_pkg::Q_W]    = req.qb;
    word[qfalu_pkg::QR_LSB +: qfalu_pkg::Q_W]    = req.qr;
    if (!quiet) begin
      while ($urandom_range(99) < STALL_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req.op;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    pending_answers.push_back(fixed_answer ? fixed : compute_answer(req));
  endtask

  // Mix of extremes, 16-bit and 8-bit values and full random words
  function automatic logic [31:0] pick_operand();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(9))
      0: w = 32'h8000_0000;
      1: w = 32'hFFFF_FFFF;
      2: w = 32'h7FFF_FFFF;
      3: w = w & 32'h0000_FFFF;
      4: w = 32'd0 - (w & 32'h0000_FFFF);
      5: w = w & 32'h0000_00FF;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [4:0] pick_q();
    case ($urandom_range(7))
      0: return 5'd0;
      1: return 5'd31;
      2, 3: return 5'($urandom_range(12));
      default: return 5'($urandom_range(31));
    endcase
  endfunction

  // Wait until every queued answer has come back
  task automatic drain_answers();
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    alu_req_t    req;
    alu_answer_t none;
    int          n;
    none = '{32'd0, 1'b0};

    add_row(qfalu_pkg::OP_ADD, 32'h0000_0000, 5'd0,  32'h0000_0000, 5'd0,  5'd0,
            1, 32'h0000_0000, 0);
    add_row(qfalu_pkg::OP_DIV, 32'h0000_0005, 5'd0,  32'h0000_0000, 5'd0,  5'd0,
            1, 32'h0000_0000, 1);
    add_row(qfalu_pkg::OP_DIV, 32'h8000_0000, 5'd0,  32'h0000_0000, 5'd0,  5'd0,
            1, 32'h0000_0000, 1);
    add_row(qfalu_pkg::OP_DIV, 32'hFFFF_FFFF, 5'd31, 32'h0000_0000, 5'd31, 5'd31,
            1, 32'h0000_0000, 1);
    add_row(qfalu_pkg::OP_ADD, 32'h7FFF_FFFF, 5'd0,  32'h0000_0001, 5'd0,  5'd0,
            1, 32'h8000_0000, 0);
    add_row(qfalu_pkg::OP_SUB, 32'h8000_0000, 5'd0,  32'h0000_0001, 5'd0,  5'd0,
            1, 32'h7FFF_FFFF, 0);
    add_row(qfalu_pkg::OP_MUL, 32'h8000_0000, 5'd0,  32'h8000_0000, 5'd0,  5'd0,
            1, 32'h0000_0000, 0);
    add_row(qfalu_pkg::OP_MUL, 32'hFFFF_FFFF, 5'd0,  32'hFFFF_FFFF, 5'd0,  5'd0,
            1, 32'h0000_0001, 0);
    add_row(qfalu_pkg::OP_DIV, 32'h8000_0000, 5'd0,  32'hFFFF_FFFF, 5'd0,  5'd0,
            1, 32'h8000_0000, 0);
    add_row(qfalu_pkg::OP_DIV, 32'h0000_0006, 5'd0,  32'h0000_0003, 5'd0,  5'd0,
            1, 32'h0000_0002, 0);
    add_row(qfalu_pkg::OP_ADD, 32'h0000_0001, 5'd0,  32'h0000_0000, 5'd0,  5'd31,
            1, 32'h8000_0000, 0);
    add_row(qfalu_pkg::OP_ADD, 32'h8000_0000, 5'd31, 32'h0000_0000, 5'd0,  5'd0,
            1, 32'hFFFF_FFFF, 0);
    add_row(qfalu_pkg::OP_ADD, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF, 5'd31, 5'd31,
            1, 32'hFFFF_FFFE, 0);
    // longest divide, shortest divide, exact divide with fraction steps
    add_row(qfalu_pkg::OP_DIV, 32'h0000_0001, 5'd0,  32'h0000_0001, 5'd31, 5'd31,
            0, 32'd0, 0);
    add_row(qfalu_pkg::OP_DIV, 32'h7FFF_FFFF, 5'd31, 32'h0000_0001, 5'd0,  5'd0,
            0, 32'd0, 0);
    add_row(qfalu_pkg::OP_DIV, 32'h0000_0060, 5'd4,  32'h0000_0030, 5'd4,  5'd8,
            0, 32'd0, 0);
    add_row(qfalu_pkg::OP_DIV, 32'hFFFF_FFF9, 5'd0,  32'h0000_0002, 5'd0,  5'd16,
            0, 32'd0, 0);
    add_row(qfalu_pkg::OP_DIV, 32'h0000_0000, 5'd3,  32'h0000_0005, 5'd7,  5'd9,
            0, 32'd0, 0);
    add_row(qfalu_pkg::OP_MUL, 32'h0000_0003, 5'd0,  32'hFFFF_FFFB, 5'd0,  5'd31,
            0, 32'd0, 0);
    add_row(qfalu_pkg::OP_MUL, 32'h7FFF_FFFF, 5'd31, 32'h8000_0000, 5'd31, 5'd0,
            0, 32'd0, 0);
    add_row(qfalu_pkg::OP_MUL, 32'h0000_0000, 5'd5,  32'hFFFF_FFFD, 5'd2,  5'd4,
            0, 32'd0, 0);
    add_row(qfalu_pkg::OP_SUB, 32'h1234_5678, 5'd8,  32'h8765_4321, 5'd20, 5'd12,
            0, 32'd0, 0);
    add_row(qfalu_pkg::OP_SUB, 32'h8000_0000, 5'd31, 32'h7FFF_FFFF, 5'd0,  5'd31,
            0, 32'd0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_req(directed_rows[i].req, directed_rows[i].fixed_answer, directed_rows[i].answer);
    drain_answers();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= QUIET_FIRST && n < QUIET_LAST);
      if (n == HOLD_AT)
        drain_answers();
      req.op = qfalu_pkg::op_t'($urandom_range(3));
      req.a  = pick_operand();
      req.b  = pick_operand();
      // keep most divides well-formed, with an occasional zero divisor
      if (req.op == qfalu_pkg::OP_DIV && $urandom_range(19) == 0)
        req.b = 32'd0;
      req.qa = pick_q();
      req.qb = pick_q();
      req.qr = ($urandom_range(5) == 0) ? req.qa : pick_q();
      send_req(req, 1'b0, none);
    end
    quiet = 1'b0;
    drain_answers();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("PASS qformat_fixed_point_alu");
    else
      $display("FAIL qformat_fixed_point_alu");
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= STALL_PCT);
  end

  // Compare each result transfer with the oldest queued answer
  always @(posedge clk) begin
    alu_answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: result=%h divide_by_zero=%b",
                 $time, out_tdata, out_tuser);
      end else begin
        want = pending_answers.pop_front();
        if (out_tdata !== want.value) begin
          mismatch_count++;
          $display("%0t: result mismatch: expected %h, actual %h",
                   $time, want.value, out_tdata);
        end
        if (out_tuser !== want.dz) begin
          mismatch_count++;
          $display("%0t: divide_by_zero mismatch: expected %b, actual %b",
                   $time, want.dz, out_tuser);
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
      $display("FAIL qformat_fixed_point_alu");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== qformat_fixed_point_alu.f =====
+incdir+src
src/qfalu_pkg.sv
src/qfalu_ctrl.sv
src/qfalu_dp.sv
src/qformat_fixed_point_alu.sv
src/qfalu_checker.sv
tb/tb.sv
